// ===== sv/apcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// apcsc_pkg
// Shared types and constants of the per-class adaptive handle cache.
// ----------------------------------------------------------------------------
package apcsc_pkg;

	// geometry
	localparam int NUM_CLASSES = 8;
	localparam int STACK_DEPTH = 128;
	localparam int HANDLE_BITS = 48;
	localparam int CLASS_W     = $clog2(NUM_CLASSES);
	localparam int STACK_WORDS = NUM_CLASSES * STACK_DEPTH;
	localparam int ADDR_W      = $clog2(STACK_WORDS);

	// field widths
	localparam int COUNT_W = 8;
	localparam int LW_W    = 9;
	localparam int TICK_W  = 10;
	localparam int CAP_W   = 8;
	localparam int CFG_W   = 10;
	localparam int CFG_IDX_W = 1;

	// register indices
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD    = 1'b1;

	// reset values
	localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(100);
	localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(512);

	// request kinds
	localparam logic KIND_PUT = 1'b0;
	localparam logic KIND_GET = 1'b1;

	// per-class bookkeeping word
	typedef struct packed {
		logic [COUNT_W-1:0]     count;
		logic [COUNT_W-1:0]     target;
		logic signed [LW_W-1:0] low_water;
		logic [TICK_W-1:0]      tick;
	} meta_t;

	localparam meta_t META_RESET = '{
		count:     '0,
		target:    COUNT_W'(1),
		low_water: '0,
		tick:      TICK_RESET
	};

	// flat stack address of a slot within a class
	function automatic logic [ADDR_W-1:0] stack_addr(input logic [CLASS_W-1:0] cls,
			input logic [COUNT_W-1:0] slot);
		stack_addr = ADDR_W'(cls) * ADDR_W'(STACK_DEPTH) + ADDR_W'(slot);
	endfunction

endpackage

// ===== sv/apcsc_ram.sv =====
// ----------------------------------------------------------------------------
// apcsc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module apcsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/adaptive_per_class_slab_cache_core.sv =====
// ----------------------------------------------------------------------------
// adaptive_per_class_slab_cache_core
// Per-class LIFO handle cache with low-water-mark target adaptation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on accepted and handle_out, marked by a one-cycle done strobe, in the third
// cycle after the edge that takes the request, and must be captured then since
// the block cannot be stalled. A new request can be taken every 2 cycles: in
// the first the class's bookkeeping word, read at the taking edge, is updated
// and written back while the handle stack memory is accessed; in the second the
// popped handle is moved to the result registers. busy is high only during the
// first of these.
module adaptive_per_class_slab_cache_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  kind,
	input  logic                                  class_valid,
	input  logic [2:0]                            class_index,
	input  logic [47:0]                           handle_in,
	input  logic                                  cfg_we,
	input  logic [apcsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [apcsc_pkg::CFG_W-1:0]           cfg_wdata,
	output logic                                  done,
	output logic                                  accepted,
	output logic [47:0]                           handle_out
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_META = 3'b010,
		ST_DATA = 3'b100
	} state_t;

	state_t state_q;

	logic [apcsc_pkg::CAP_W-1:0]  cap_q;
	logic [apcsc_pkg::TICK_W-1:0] period_q;

	logic [apcsc_pkg::NUM_CLASSES-1:0] meta_vld_q;

	// request held during the metadata cycle
	logic                              kind_s1;
	logic                              valid_s1;
	logic [apcsc_pkg::CLASS_W-1:0]     cls_s1;
	logic [apcsc_pkg::HANDLE_BITS-1:0] handle_s1;
	logic                              meta_vld_s1;

	// outcome held during the stack cycle
	logic ok_s2;
	logic get_s2;

	logic take;

	apcsc_pkg::meta_t meta_rdata;
	apcsc_pkg::meta_t meta_cur;
	apcsc_pkg::meta_t meta_nxt;
	logic             meta_we;

	logic                                  stack_we;
	logic [apcsc_pkg::ADDR_W-1:0]          stack_waddr;
	logic [apcsc_pkg::ADDR_W-1:0]          stack_raddr;
	logic [apcsc_pkg::HANDLE_BITS-1:0]     stack_rdata;

	logic                                  req_ok;
	logic                                  req_class_ok;

	assign busy = (state_q == ST_META);
	assign take = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= apcsc_pkg::CAP_RESET;
			period_q <= apcsc_pkg::TICK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				apcsc_pkg::REG_CAPACITY_LIMIT: cap_q    <= cfg_wdata[apcsc_pkg::CAP_W-1:0];
				apcsc_pkg::REG_TICK_PERIOD:    period_q <= cfg_wdata[apcsc_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: state_q <= take ? ST_META : ST_IDLE;
				ST_META: state_q <= ST_DATA;
				ST_DATA: state_q <= take ? ST_META : ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1     <= kind;
			valid_s1    <= class_valid && (32'(class_index) < apcsc_pkg::NUM_CLASSES);
			cls_s1      <= class_index[apcsc_pkg::CLASS_W-1:0];
			handle_s1   <= handle_in[apcsc_pkg::HANDLE_BITS-1:0];
			meta_vld_s1 <= meta_vld_q[class_index[apcsc_pkg::CLASS_W-1:0]];
		end
	end

	// bookkeeping memory, an entry never written reads as its reset value
	apcsc_ram #(
		.WIDTH ($bits(apcsc_pkg::meta_t)),
		.DEPTH (apcsc_pkg::NUM_CLASSES)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (cls_s1),
		.wdata (meta_nxt),
		.raddr (class_index[apcsc_pkg::CLASS_W-1:0]),
		.rdata (meta_rdata)
	);

	assign meta_cur = meta_vld_s1 ? meta_rdata : apcsc_pkg::META_RESET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q <= '0;
		end else if (meta_we) begin
			meta_vld_q[cls_s1] <= 1'b1;
		end
	end

	// read-modify-write of the class word
	always_comb begin
		logic [apcsc_pkg::COUNT_W-1:0]    n_new;
		logic signed [apcsc_pkg::LW_W-1:0] lw_new;
		logic [apcsc_pkg::TICK_W-1:0]     tk_new;
		logic [apcsc_pkg::COUNT_W:0]      dbl;
		logic [apcsc_pkg::COUNT_W-1:0]    tgt_new;

		req_class_ok = valid_s1;
		n_new        = meta_cur.count;
		lw_new       = meta_cur.low_water;
		tgt_new      = meta_cur.target;
		req_ok       = 1'b0;

		if (kind_s1 == apcsc_pkg::KIND_PUT) begin
			req_ok = (32'(meta_cur.count) < apcsc_pkg::STACK_DEPTH)
				&& (meta_cur.count < meta_cur.target);
			if (req_ok) begin
				n_new = meta_cur.count + 1'b1;
			end
		end else begin
			req_ok = (meta_cur.count != '0);
			if (req_ok) begin
				n_new = meta_cur.count - 1'b1;
				if ($signed({1'b0, n_new}) < meta_cur.low_water) begin
					lw_new = $signed({1'b0, n_new});
				end else begin
					lw_new = -9'sd1;
				end
			end
		end

		// ticker and target adaptation
		tk_new = meta_cur.tick - 1'b1;
		dbl    = {meta_cur.target, 1'b0};
		if (tk_new == '0) begin
			tk_new = period_q;
			if (lw_new < 0) begin
				tgt_new = (dbl > {1'b0, cap_q}) ? cap_q : dbl[apcsc_pkg::COUNT_W-1:0];
			end else if (lw_new > 0 && meta_cur.target > apcsc_pkg::COUNT_W'(1)) begin
				tgt_new = meta_cur.target >> 1;
			end
			lw_new = $signed({1'b0, n_new});
		end

		meta_nxt.count     = n_new;
		meta_nxt.target    = tgt_new;
		meta_nxt.low_water = lw_new;
		meta_nxt.tick      = tk_new;
	end

	assign meta_we = (state_q == ST_META) && req_class_ok;

	// handle stack memory
	assign stack_we    = meta_we && (kind_s1 == apcsc_pkg::KIND_PUT) && req_ok;
	assign stack_waddr = apcsc_pkg::stack_addr(cls_s1, meta_cur.count);
	assign stack_raddr = apcsc_pkg::stack_addr(cls_s1, meta_cur.count - 1'b1);

	apcsc_ram #(
		.WIDTH (apcsc_pkg::HANDLE_BITS),
		.DEPTH (apcsc_pkg::STACK_WORDS)
	) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_waddr),
		.wdata (handle_s1),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

	// outcome into the stack cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_META) begin
			ok_s2  <= req_class_ok && req_ok;
			get_s2 <= (kind_s1 == apcsc_pkg::KIND_GET);
		end
	end

	// result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_DATA);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DATA) begin
			accepted   <= ok_s2;
			handle_out <= (ok_s2 && get_s2) ? 48'(stack_rdata) : '0;
		end
	end

	// checks
	a_done_after_data: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DATA))
		else $error("result strobe without a completed stack cycle");

	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	a_handle_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && handle_out != '0) |-> accepted)
		else $error("handle returned without a hit");

	a_push_on_put: assert property (@(posedge clk) disable iff (!arst_n)
		stack_we |-> (kind_s1 == apcsc_pkg::KIND_PUT) && valid_s1 && (state_q == ST_META))
		else $error("stack written outside a valid put");

endmodule
